@@ hdl/stt_pkg.sv @@
// ----------------------------------------------------------------------------
// stt_pkg: shared types and constants of the source text tokenizer
// Character codes, token kinds, lexer modes, result record and queue sizes.
// ----------------------------------------------------------------------------
package stt_pkg;

	// token length counter width and its saturation value
	localparam int LEN_W = 16;
	localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

	// result queue sizing
	localparam int QD     = 4;
	localparam int QPTR_W = $clog2(QD);
	localparam int QCNT_W = $clog2(QD + 1);

	// lexer modes
	localparam logic [2:0] MODE_IDLE    = 3'd0;
	localparam logic [2:0] MODE_NUMBER  = 3'd1;
	localparam logic [2:0] MODE_IDENT   = 3'd2;
	localparam logic [2:0] MODE_EQUALS  = 3'd3;
	localparam logic [2:0] MODE_STRING  = 3'd4;
	localparam logic [2:0] MODE_ESCAPE  = 3'd5;
	localparam logic [2:0] MODE_COMMENT = 3'd6;
	localparam logic [2:0] MODE_HALT    = 3'd7;

	// token kinds
	localparam logic [3:0] K_NUMBER = 4'd0;
	localparam logic [3:0] K_STRING = 4'd1;
	localparam logic [3:0] K_OPAREN = 4'd2;
	localparam logic [3:0] K_CPAREN = 4'd3;
	localparam logic [3:0] K_OBRACE = 4'd4;
	localparam logic [3:0] K_CBRACE = 4'd5;
	localparam logic [3:0] K_EQUALS = 4'd6;
	localparam logic [3:0] K_ARROW  = 4'd7;
	localparam logic [3:0] K_IDENT  = 4'd8;
	localparam logic [3:0] K_END    = 4'd9;
	localparam logic [3:0] K_SCHAR  = 4'd10;
	localparam logic [3:0] K_ICHAR  = 4'd11;
	localparam logic [3:0] K_ERROR  = 4'd12;

	// error codes
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_UNEXP    = 2'd1;
	localparam logic [1:0] ERR_ESCAPE   = 2'd2;
	localparam logic [1:0] ERR_UNTERM   = 2'd3;

	// character codes
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_OPAREN = 8'h28;
	localparam logic [7:0] CH_CPAREN = 8'h29;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_EQUALS = 8'h3D;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UZ     = 8'h5A;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LN     = 8'h6E;
	localparam logic [7:0] CH_LT     = 8'h74;
	localparam logic [7:0] CH_LZ     = 8'h7A;
	localparam logic [7:0] CH_OBRACE = 8'h7B;
	localparam logic [7:0] CH_CBRACE = 8'h7D;

	// one result record
	typedef struct packed {
		logic [3:0]  kind;
		logic [31:0] value;
		logic [7:0]  chr;
		logic [1:0]  err;
		logic        last;
	} tok_t;

	// results caused by one input byte (zero, one or two)
	typedef struct packed {
		logic [1:0] cnt;
		tok_t       r0;
		tok_t       r1;
	} emit_t;

	function automatic logic is_space(input logic [7:0] b);
		return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
	endfunction

	function automatic logic is_decimal(input logic [7:0] b);
		return (b >= CH_ZERO) && (b <= CH_NINE);
	endfunction

	function automatic logic is_alpha(input logic [7:0] b);
		return ((b >= CH_UA) && (b <= CH_UZ)) || ((b >= CH_LA) && (b <= CH_LZ)) ||
			(b == CH_UNDER);
	endfunction

endpackage

@@ hdl/stt_ifs.sv @@
// ----------------------------------------------------------------------------
// stt_ifs: channel interfaces of the source text tokenizer
// Byte input channel and token output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface stt_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;

	modport source (output valid, output text_byte, input ready);
	modport sink   (input valid, input text_byte, output ready);
endinterface

interface stt_tok_if;
	logic        valid;
	logic        ready;
	logic [3:0]  token_kind;
	logic [31:0] token_value;
	logic [7:0]  char_byte;
	logic [1:0]  error_code;
	logic        last_of_run;

	modport source (output valid, output token_kind, output token_value, output char_byte,
		output error_code, output last_of_run, input ready);
	modport sink   (input valid, input token_kind, input token_value, input char_byte,
		input error_code, input last_of_run, output ready);
endinterface

@@ hdl/source_text_tokenizer_unit.sv @@
// ----------------------------------------------------------------------------
// source_text_tokenizer_unit: streaming lexer, one source byte per beat
// Decodes text into tokens, char results and errors, halting at end or error.
//
//   channel   dir  beat contents
//   text_in   in   text_byte
//   tok_out   out  token_kind, token_value, char_byte, error_code, last_of_run
//
// A byte is decoded in the cycle it is accepted; its results are registered
// into a four-entry result queue and leave one per cycle while tok_out.ready
// is high. Input runs at one byte per cycle while the queue drains; a byte
// that yields two results takes two queue entries, and text_in.ready drops
// when fewer than two queue entries are free.
// Reset clears the lexer to idle and empties the queue. After an end token
// or an error every further byte is accepted and dropped until reset.
// ----------------------------------------------------------------------------
module source_text_tokenizer_unit (
	input  logic      clk,
	input  logic      arst_n,
	stt_byte_if.sink  text_in,
	stt_tok_if.source tok_out
);

	logic           take;
	logic           room;
	stt_pkg::emit_t emit;

	assign text_in.ready = room;
	assign take          = text_in.valid && text_in.ready;

	// lexer state and decode
	stt_lex_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.text_byte (text_in.text_byte),
		.emit      (emit)
	);

	// result buffering
	stt_res_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (take),
		.emit    (emit),
		.room    (room),
		.tok_out (tok_out)
	);

endmodule

@@ hdl/stt_lex_core.sv @@
// ----------------------------------------------------------------------------
// stt_lex_core: lexer state and per-byte decode
// Holds mode, number accumulator and token length; decodes one byte per
// accepted beat into up to two result records.
// ----------------------------------------------------------------------------
module stt_lex_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           take,
	input  logic [7:0]     text_byte,
	output stt_pkg::emit_t emit
);

	logic [2:0]                mode_q;
	logic [31:0]               acc_q;
	logic [stt_pkg::LEN_W-1:0] len_q;

	logic [2:0]                nx_mode;
	logic [31:0]               nx_acc;
	logic [stt_pkg::LEN_W-1:0] nx_len;

	logic                      id_vld;
	stt_pkg::tok_t             id_tok;
	logic [2:0]                id_mode;
	logic [31:0]               id_acc;
	logic [stt_pkg::LEN_W-1:0] id_len;

	logic                      pre_vld;
	stt_pkg::tok_t             pre_tok;
	logic                      use_idle;
	logic [stt_pkg::LEN_W-1:0] len_inc;
	logic [31:0]               acc_mac;
	logic [7:0]                digit;

	assign digit   = text_byte - stt_pkg::CH_ZERO;
	assign len_inc = (len_q == stt_pkg::LEN_MAX) ? len_q : len_q + 1'b1;
	assign acc_mac = (acc_q << 3) + (acc_q << 1) + 32'(digit);

	// byte handled as in idle mode
	always_comb begin
		id_vld  = 1'b0;
		id_tok  = '0;
		id_mode = stt_pkg::MODE_IDLE;
		id_acc  = acc_q;
		id_len  = len_q;
		priority if (text_byte == stt_pkg::CH_NUL) begin
			id_vld      = 1'b1;
			id_tok.kind = stt_pkg::K_END;
			id_mode     = stt_pkg::MODE_HALT;
		end else if (stt_pkg::is_space(text_byte)) begin
			id_mode = stt_pkg::MODE_IDLE;
		end else if (text_byte == stt_pkg::CH_DOLLAR) begin
			id_mode = stt_pkg::MODE_COMMENT;
		end else if (text_byte == stt_pkg::CH_OPAREN) begin
			id_vld      = 1'b1;
			id_tok.kind = stt_pkg::K_OPAREN;
		end else if (text_byte == stt_pkg::CH_CPAREN) begin
			id_vld      = 1'b1;
			id_tok.kind = stt_pkg::K_CPAREN;
		end else if (text_byte == stt_pkg::CH_OBRACE) begin
			id_vld      = 1'b1;
			id_tok.kind = stt_pkg::K_OBRACE;
		end else if (text_byte == stt_pkg::CH_CBRACE) begin
			id_vld      = 1'b1;
			id_tok.kind = stt_pkg::K_CBRACE;
		end else if (text_byte == stt_pkg::CH_EQUALS) begin
			id_mode = stt_pkg::MODE_EQUALS;
		end else if (text_byte == stt_pkg::CH_QUOTE) begin
			id_len  = '0;
			id_mode = stt_pkg::MODE_STRING;
		end else if (stt_pkg::is_alpha(text_byte)) begin
			id_len      = stt_pkg::LEN_W'(1);
			id_vld      = 1'b1;
			id_tok.kind = stt_pkg::K_ICHAR;
			id_tok.chr  = text_byte;
			id_mode     = stt_pkg::MODE_IDENT;
		end else if (stt_pkg::is_decimal(text_byte)) begin
			id_acc  = 32'(digit);
			id_mode = stt_pkg::MODE_NUMBER;
		end else begin
			id_vld      = 1'b1;
			id_tok.kind = stt_pkg::K_ERROR;
			id_tok.chr  = text_byte;
			id_tok.err  = stt_pkg::ERR_UNEXP;
			id_mode     = stt_pkg::MODE_HALT;
		end
	end

	// mode dispatch: first result, then optional idle handling
	always_comb begin
		pre_vld  = 1'b0;
		pre_tok  = '0;
		use_idle = 1'b0;
		nx_mode  = mode_q;
		nx_acc   = acc_q;
		nx_len   = len_q;
		unique case (mode_q)
			stt_pkg::MODE_HALT: begin
				nx_mode = stt_pkg::MODE_HALT;
			end
			stt_pkg::MODE_NUMBER: begin
				if (stt_pkg::is_decimal(text_byte)) begin
					nx_acc = acc_mac;
				end else begin
					pre_vld       = 1'b1;
					pre_tok.kind  = stt_pkg::K_NUMBER;
					pre_tok.value = acc_q;
					use_idle      = 1'b1;
				end
			end
			stt_pkg::MODE_IDENT: begin
				if (stt_pkg::is_decimal(text_byte) || stt_pkg::is_alpha(text_byte)) begin
					nx_len       = len_inc;
					pre_vld      = 1'b1;
					pre_tok.kind = stt_pkg::K_ICHAR;
					pre_tok.chr  = text_byte;
				end else begin
					pre_vld       = 1'b1;
					pre_tok.kind  = stt_pkg::K_IDENT;
					pre_tok.value = 32'(len_q);
					use_idle      = 1'b1;
				end
			end
			stt_pkg::MODE_EQUALS: begin
				pre_vld = 1'b1;
				if (text_byte == stt_pkg::CH_GT) begin
					pre_tok.kind = stt_pkg::K_ARROW;
					nx_mode      = stt_pkg::MODE_IDLE;
				end else begin
					pre_tok.kind = stt_pkg::K_EQUALS;
					use_idle     = 1'b1;
				end
			end
			stt_pkg::MODE_STRING: begin
				priority if (text_byte == stt_pkg::CH_QUOTE) begin
					pre_vld       = 1'b1;
					pre_tok.kind  = stt_pkg::K_STRING;
					pre_tok.value = 32'(len_q);
					nx_mode       = stt_pkg::MODE_IDLE;
				end else if (text_byte == stt_pkg::CH_BSLASH) begin
					nx_mode = stt_pkg::MODE_ESCAPE;
				end else if (text_byte == stt_pkg::CH_NUL) begin
					pre_vld      = 1'b1;
					pre_tok.kind = stt_pkg::K_ERROR;
					pre_tok.err  = stt_pkg::ERR_UNTERM;
					nx_mode      = stt_pkg::MODE_HALT;
				end else begin
					nx_len       = len_inc;
					pre_vld      = 1'b1;
					pre_tok.kind = stt_pkg::K_SCHAR;
					pre_tok.chr  = text_byte;
				end
			end
			stt_pkg::MODE_ESCAPE: begin
				pre_vld = 1'b1;
				priority if (text_byte == stt_pkg::CH_NUL) begin
					pre_tok.kind = stt_pkg::K_ERROR;
					pre_tok.err  = stt_pkg::ERR_UNTERM;
					nx_mode      = stt_pkg::MODE_HALT;
				end else if (text_byte == stt_pkg::CH_LN || text_byte == stt_pkg::CH_LT ||
					text_byte == stt_pkg::CH_ZERO || text_byte == stt_pkg::CH_QUOTE ||
					text_byte == stt_pkg::CH_BSLASH) begin
					nx_len       = len_inc;
					pre_tok.kind = stt_pkg::K_SCHAR;
					nx_mode      = stt_pkg::MODE_STRING;
					priority if (text_byte == stt_pkg::CH_LN) begin
						pre_tok.chr = stt_pkg::CH_LF;
					end else if (text_byte == stt_pkg::CH_LT) begin
						pre_tok.chr = stt_pkg::CH_TAB;
					end else if (text_byte == stt_pkg::CH_ZERO) begin
						pre_tok.chr = stt_pkg::CH_NUL;
					end else begin
						pre_tok.chr = text_byte;
					end
				end else begin
					pre_tok.kind = stt_pkg::K_ERROR;
					pre_tok.chr  = text_byte;
					pre_tok.err  = stt_pkg::ERR_ESCAPE;
					nx_mode      = stt_pkg::MODE_HALT;
				end
			end
			stt_pkg::MODE_COMMENT: begin
				if (text_byte == stt_pkg::CH_LF) begin
					nx_mode = stt_pkg::MODE_IDLE;
				end else if (text_byte == stt_pkg::CH_NUL) begin
					pre_vld      = 1'b1;
					pre_tok.kind = stt_pkg::K_END;
					nx_mode      = stt_pkg::MODE_HALT;
				end
			end
			stt_pkg::MODE_IDLE: begin
				use_idle = 1'b1;
			end
		endcase
		if (use_idle) begin
			nx_mode = id_mode;
			nx_acc  = id_acc;
			nx_len  = id_len;
		end
	end

	// pack results and mark the last one
	always_comb begin
		emit = '0;
		if (pre_vld && use_idle && id_vld) begin
			emit.cnt     = 2'd2;
			emit.r0      = pre_tok;
			emit.r1      = id_tok;
			emit.r1.last = 1'b1;
		end else if (pre_vld) begin
			emit.cnt     = 2'd1;
			emit.r0      = pre_tok;
			emit.r0.last = 1'b1;
		end else if (use_idle && id_vld) begin
			emit.cnt     = 2'd1;
			emit.r0      = id_tok;
			emit.r0.last = 1'b1;
		end
	end

	// state update on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= stt_pkg::MODE_IDLE;
			acc_q  <= '0;
			len_q  <= '0;
		end else if (take) begin
			mode_q <= nx_mode;
			acc_q  <= nx_acc;
			len_q  <= nx_len;
		end
	end

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == stt_pkg::MODE_HALT) |=> (mode_q == stt_pkg::MODE_HALT))
		else $error("lexer left halt mode");

	a_two_last: assert property (@(posedge clk) disable iff (!arst_n)
		(emit.cnt == 2'd2) |-> (emit.r1.last && !emit.r0.last))
		else $error("last mark misplaced on a two-result beat");

	a_end_halts: assert property (@(posedge clk) disable iff (!arst_n)
		(take && emit.cnt == 2'd1 &&
		(emit.r0.kind == stt_pkg::K_ERROR || emit.r0.kind == stt_pkg::K_END))
		|=> (mode_q == stt_pkg::MODE_HALT))
		else $error("end or error did not halt the lexer");

endmodule

@@ hdl/stt_res_queue.sv @@
// ----------------------------------------------------------------------------
// stt_res_queue: result queue
// Four-entry queue of result records; takes up to two per beat and
// presents one per cycle on the token channel while its ready is high.
// ----------------------------------------------------------------------------
module stt_res_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  stt_pkg::emit_t emit,
	output logic           room,
	stt_tok_if.source      tok_out
);

	stt_pkg::tok_t              slot_q [stt_pkg::QD];
	logic [stt_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [stt_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [stt_pkg::QCNT_W-1:0] cnt_q;

	logic [1:0]                 wr_n;
	logic                       pop;
	logic [stt_pkg::QPTR_W-1:0] wr_ptr_p1;
	stt_pkg::tok_t              head;

	assign wr_n      = push ? emit.cnt : 2'd0;
	assign pop       = tok_out.valid && tok_out.ready;
	assign wr_ptr_p1 = wr_ptr_q + 1'b1;
	assign room      = (cnt_q <= stt_pkg::QCNT_W'(stt_pkg::QD - 2));

	// output side
	assign head                = slot_q[rd_ptr_q];
	assign tok_out.valid       = (cnt_q != '0);
	assign tok_out.token_kind  = head.kind;
	assign tok_out.token_value = head.value;
	assign tok_out.char_byte   = head.chr;
	assign tok_out.error_code  = head.err;
	assign tok_out.last_of_run = head.last;

	// entry writes, up to two per beat
	always_ff @(posedge clk) begin
		for (int i = 0; i < stt_pkg::QD; i++) begin
			if (wr_n != 2'd0 && wr_ptr_q == stt_pkg::QPTR_W'(i)) begin
				slot_q[i] <= emit.r0;
			end else if (wr_n == 2'd2 && wr_ptr_p1 == stt_pkg::QPTR_W'(i)) begin
				slot_q[i] <= emit.r1;
			end
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + stt_pkg::QPTR_W'(wr_n);
			rd_ptr_q <= rd_ptr_q + stt_pkg::QPTR_W'(pop);
			cnt_q    <= cnt_q + stt_pkg::QCNT_W'(wr_n) - stt_pkg::QCNT_W'(pop);
		end
	end

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= stt_pkg::QCNT_W'(stt_pkg::QD))
		else $error("result queue overfilled");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("empty queue with pointers apart");

	a_double_push: assert property (@(posedge clk) disable iff (!arst_n)
		(push && emit.cnt == 2'd2 && !pop) |=>
		(cnt_q == $past(cnt_q) + stt_pkg::QCNT_W'(2)))
		else $error("two-result beat not fully queued");

endmodule
